### rtl/triangle_face_normal_macros.svh
// Assertion macros shared by the triangle face normal RTL.
// Included by tfn_sqrt_cell, tfn_div_cell and triangle_face_normal.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("triangle_face_normal: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("triangle_face_normal: check failed");

`else

`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/tfn_pkg.sv
// Types shared by the triangle face normal block.
// No dependencies; used by tfn_front, the cells and the top level.
package tfn_pkg;

   localparam int FIELD_WIDTH = 16;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] first_x;
      logic signed [FIELD_WIDTH-1:0] first_y;
      logic signed [FIELD_WIDTH-1:0] first_z;
      logic signed [FIELD_WIDTH-1:0] second_x;
      logic signed [FIELD_WIDTH-1:0] second_y;
      logic signed [FIELD_WIDTH-1:0] second_z;
      logic signed [FIELD_WIDTH-1:0] third_x;
      logic signed [FIELD_WIDTH-1:0] third_y;
      logic signed [FIELD_WIDTH-1:0] third_z;
   } tfn_req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] normal_x;
      logic signed [FIELD_WIDTH-1:0] normal_y;
      logic signed [FIELD_WIDTH-1:0] normal_z;
      logic                          degenerate;
   } tfn_rsp_type;

   // Per-item side information carried down the cell chains.
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tfn_flags_type;

endpackage

### rtl/tfn_front.sv
// Front end: edge vectors, cross product, magnitudes and squared length.
// Depends on tfn_pkg. Six register stages, all advanced by en.
module tfn_front #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tfn_pkg::tfn_req_type  in_req,
   output logic                  out_valid,
   output logic [2*W:0]          out_mag [3],
   output logic [4*W+3:0]        out_sum,
   output tfn_pkg::tfn_flags_type out_flags
);
   import tfn_pkg::*;

   localparam int DW = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int CW = 2 * W + 3;
   localparam int MW = 2 * W + 1;
   localparam int H  = (MW + 1) / 2;
   localparam int HW = MW - H;
   localparam int SW = 4 * W + 4;

   logic [FIELD_WIDTH-1:0]  fld [9];
   logic [W+FIELD_WIDTH-1:0] ext [9];
   logic [W-1:0]            crd [9];

   logic [5:0]              v_ff;
   logic signed [DW-1:0]    a_in [3];
   logic signed [DW-1:0]    b_in [3];
   logic signed [DW-1:0]    a_ff [3];
   logic signed [DW-1:0]    b_ff [3];
   logic signed [PW-1:0]    p_in [6];
   logic signed [PW-1:0]    p_ff [6];
   logic signed [CW-1:0]    c_in [3];
   logic signed [CW-1:0]    c_ff [3];
   logic [CW-1:0]           cabs [3];
   logic [MW-1:0]           m_in [3];
   logic [MW-1:0]           m4_ff [3];
   logic [MW-1:0]           m5_ff [3];
   logic [MW-1:0]           m6_ff [3];
   logic [2*HW-1:0]         hh_ff [3];
   logic [HW+H-1:0]         hl_ff [3];
   logic [2*H-1:0]          ll_ff [3];
   logic [SW-1:0]           sq_in [3];
   logic [SW-1:0]           sq_ff [3];
   logic [SW-1:0]           sum_ff;
   tfn_flags_type           fl_in;
   tfn_flags_type           fl4_ff;
   tfn_flags_type           fl5_ff;
   tfn_flags_type           fl6_ff;

   assign fld[0] = in_req.first_x;
   assign fld[1] = in_req.first_y;
   assign fld[2] = in_req.first_z;
   assign fld[3] = in_req.second_x;
   assign fld[4] = in_req.second_y;
   assign fld[5] = in_req.second_z;
   assign fld[6] = in_req.third_x;
   assign fld[7] = in_req.third_y;
   assign fld[8] = in_req.third_z;

   // Each field is read in its low W bits; above 16 bits the field is zero-filled.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         ext[i] = {{W{1'b0}}, fld[i]};
         crd[i] = ext[i][W-1:0];
      end
      for (int k = 0; k < 3; k++) begin
         a_in[k] = $signed({crd[k][W-1], crd[k]}) - $signed({crd[3+k][W-1], crd[3+k]});
         b_in[k] = $signed({crd[6+k][W-1], crd[6+k]}) - $signed({crd[3+k][W-1], crd[3+k]});
      end
   end

   always_comb begin
      p_in[0] = a_ff[1] * b_ff[2];
      p_in[1] = a_ff[2] * b_ff[1];
      p_in[2] = a_ff[2] * b_ff[0];
      p_in[3] = a_ff[0] * b_ff[2];
      p_in[4] = a_ff[0] * b_ff[1];
      p_in[5] = a_ff[1] * b_ff[0];
      for (int k = 0; k < 3; k++) begin
         c_in[k] = $signed({p_ff[2*k][PW-1], p_ff[2*k]})
                 - $signed({p_ff[2*k+1][PW-1], p_ff[2*k+1]});
      end
   end

   always_comb begin
      fl_in.degen = 1'b1;
      for (int k = 0; k < 3; k++) begin
         cabs[k] = c_ff[k][CW-1] ? CW'(-c_ff[k]) : CW'(c_ff[k]);
         m_in[k] = cabs[k][MW-1:0];
         fl_in.neg[k] = !c_ff[k][CW-1] && (c_ff[k] != '0);
         if (c_ff[k] != '0) begin
            fl_in.degen = 1'b0;
         end
      end
   end

   // Squares are built from half-width partial products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = (SW'(hh_ff[k]) << (2 * H)) + (SW'(hl_ff[k]) << (H + 1))
                  + SW'(ll_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k]  <= a_in[k];
            b_ff[k]  <= b_in[k];
            c_ff[k]  <= c_in[k];
            m4_ff[k] <= m_in[k];
            hh_ff[k] <= m_in[k][MW-1:H] * m_in[k][MW-1:H];
            hl_ff[k] <= m_in[k][MW-1:H] * m_in[k][H-1:0];
            ll_ff[k] <= m_in[k][H-1:0] * m_in[k][H-1:0];
            m5_ff[k] <= m4_ff[k];
            sq_ff[k] <= sq_in[k];
            m6_ff[k] <= m5_ff[k];
         end
         for (int j = 0; j < 6; j++) begin
            p_ff[j] <= p_in[j];
         end
         fl4_ff <= fl_in;
         fl5_ff <= fl4_ff;
         fl6_ff <= fl5_ff;
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   assign out_valid = v_ff[5];
   assign out_mag   = m6_ff;
   assign out_sum   = sum_ff;
   assign out_flags = fl6_ff;

endmodule

### rtl/tfn_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per item.
// Depends on tfn_pkg and triangle_face_normal_macros.svh.
`include "triangle_face_normal_macros.svh"
module tfn_sqrt_cell #(
   parameter int N  = 34,
   parameter int MW = 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2*N-1:0]         in_x,
   input  logic [N+2:0]           in_r,
   input  logic [N-1:0]           in_q,
   input  logic [MW-1:0]          in_mag [3],
   input  tfn_pkg::tfn_flags_type in_flags,
   output logic                   out_valid,
   output logic [2*N-1:0]         out_x,
   output logic [N+2:0]           out_r,
   output logic [N-1:0]           out_q,
   output logic [MW-1:0]          out_mag [3],
   output tfn_pkg::tfn_flags_type out_flags
);
   import tfn_pkg::*;

   logic                valid_ff;
   logic [2*N-1:0]      x_ff;
   logic [N+2:0]        r_ff;
   logic [N-1:0]        q_ff;
   logic [MW-1:0]       mag_ff [3];
   tfn_flags_type       flags_ff;
   logic [N+2:0]        rr;
   logic [N+2:0]        trial;
   logic                fits;
   logic [N+2:0]        r_in;

   // Bring down the next two radicand bits and try appending a one to the root.
   always_comb begin
      rr    = {in_r[N:0], in_x[2*N-1 -: 2]};
      trial = {1'b0, in_q, 2'b01};
      fits  = rr >= trial;
      r_in  = fits ? rr - trial : rr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= {in_x[2*N-3:0], 2'b00};
         r_ff     <= r_in;
         q_ff     <= {in_q[N-2:0], fits};
         mag_ff   <= in_mag;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_r     = r_ff;
   assign out_q     = q_ff;
   assign out_mag   = mag_ff;
   assign out_flags = flags_ff;

   `TFN_ASSERT_IMP(a_rem_bound, clock, reset, valid_ff, r_ff <= {2'b00, q_ff, 1'b0})

endmodule

### rtl/tfn_div_cell.sv
// One cell of the divider chain: one quotient bit for all three components.
// Depends on tfn_pkg and triangle_face_normal_macros.svh.
`include "triangle_face_normal_macros.svh"
module tfn_div_cell #(
   parameter int N     = 34,
   parameter int F     = 14,
   parameter bit FIRST = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [N-1:0]           in_s,
   input  logic [N:0]             in_r [3],
   input  logic [F:0]             in_q [3],
   input  tfn_pkg::tfn_flags_type in_flags,
   output logic                   out_valid,
   output logic [N-1:0]           out_s,
   output logic [N:0]             out_r [3],
   output logic [F:0]             out_q [3],
   output tfn_pkg::tfn_flags_type out_flags
);
   import tfn_pkg::*;

   logic          valid_ff;
   logic [N-1:0]  s_ff;
   logic [N:0]    r_ff [3];
   logic [F:0]    q_ff [3];
   tfn_flags_type flags_ff;
   logic [N:0]    rr [3];
   logic [2:0]    fits;
   logic [N:0]    r_in [3];

   // The first cell takes the integer bit, so it compares without a shift.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rr[k]   = FIRST ? in_r[k] : {in_r[k][N-1:0], 1'b0};
         fits[k] = rr[k] >= {1'b0, in_s};
         r_in[k] = fits[k] ? rr[k] - {1'b0, in_s} : rr[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= in_s;
         flags_ff <= in_flags;
         for (int k = 0; k < 3; k++) begin
            r_ff[k] <= r_in[k];
            q_ff[k] <= {in_q[k][F-1:0], fits[k]};
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_r     = r_ff;
   assign out_q     = q_ff;
   assign out_flags = flags_ff;

   `TFN_ASSERT_IMP(a_rem_below, clock, reset, valid_ff && s_ff != '0, r_ff[0] < {1'b0, s_ff} && r_ff[1] < {1'b0, s_ff} && r_ff[2] < {1'b0, s_ff})
   `TFN_ASSERT_NEXT(a_degen_len, clock, reset, en && in_valid && in_flags.degen, s_ff == '0)

endmodule

### rtl/triangle_face_normal.sv
// Top level of the triangle face normal engine.
// Depends on tfn_pkg, tfn_front, tfn_sqrt_cell, tfn_div_cell and the macro header.
//
//   channel  | direction | handshake           | payload
//   req      | in        | req_valid/req_ready | tfn_req_type, three vertices
//   rsp      | out       | rsp_valid/rsp_ready | tfn_rsp_type, unit normal and flag
//
// One triangle is taken every cycle while req_ready is high; each item passes through
// tfn_front, the square-root cell chain, one root bit per cell, the divider chain,
// one quotient bit per cell, and the output register.
// Reset clears only the valid bits; there is no clearing pass.
// The whole pipeline holds while a result waits in the output register unaccepted.
`include "triangle_face_normal_macros.svh"
module triangle_face_normal #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tfn_pkg::tfn_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tfn_pkg::tfn_rsp_type rsp_payload
);
   import tfn_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = NORMAL_FRAC_BITS;
   localparam int MW = 2 * W + 1;
   localparam int N  = 2 * W + 2;

   logic               en;
   logic               fr_valid;
   logic [MW-1:0]      fr_mag [3];
   logic [2*N-1:0]     fr_sum;
   tfn_flags_type      fr_flags;

   logic               sq_valid [N+1];
   logic [2*N-1:0]     sq_x     [N+1];
   logic [N+2:0]       sq_r     [N+1];
   logic [N-1:0]       sq_q     [N+1];
   logic [MW-1:0]      sq_mag   [N+1][3];
   tfn_flags_type      sq_flags [N+1];

   logic               dv_valid [F+2];
   logic [N-1:0]       dv_s     [F+2];
   logic [N:0]         dv_r     [F+2][3];
   logic [F:0]         dv_q     [F+2][3];
   tfn_flags_type      dv_flags [F+2];

   logic               rsp_valid_ff;
   tfn_rsp_type        rsp_payload_ff;
   tfn_rsp_type        rsp_payload_in;
   logic [F:0]         qc [3];
   logic signed [F+1:0] qs [3];
   logic [FIELD_WIDTH-1:0] comp [3];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   tfn_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req_payload),
      .out_valid (fr_valid),
      .out_mag   (fr_mag),
      .out_sum   (fr_sum),
      .out_flags (fr_flags)
   );

   assign sq_valid[0] = fr_valid;
   assign sq_x[0]     = fr_sum;
   assign sq_r[0]     = '0;
   assign sq_q[0]     = '0;
   assign sq_mag[0]   = fr_mag;
   assign sq_flags[0] = fr_flags;

   for (genvar i = 0; i < N; i++) begin : g_sqrt
      tfn_sqrt_cell #(.N(N), .MW(MW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_x      (sq_x[i]),
         .in_r      (sq_r[i]),
         .in_q      (sq_q[i]),
         .in_mag    (sq_mag[i]),
         .in_flags  (sq_flags[i]),
         .out_valid (sq_valid[i+1]),
         .out_x     (sq_x[i+1]),
         .out_r     (sq_r[i+1]),
         .out_q     (sq_q[i+1]),
         .out_mag   (sq_mag[i+1]),
         .out_flags (sq_flags[i+1])
      );
   end

   assign dv_valid[0] = sq_valid[N];
   assign dv_s[0]     = sq_q[N];
   assign dv_flags[0] = sq_flags[N];

   for (genvar k = 0; k < 3; k++) begin : g_div_in
      assign dv_r[0][k] = {{(N+1-MW){1'b0}}, sq_mag[N][k]};
      assign dv_q[0][k] = '0;
   end

   for (genvar j = 0; j <= F; j++) begin : g_div
      tfn_div_cell #(.N(N), .F(F), .FIRST(j == 0)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[j]),
         .in_s      (dv_s[j]),
         .in_r      (dv_r[j]),
         .in_q      (dv_q[j]),
         .in_flags  (dv_flags[j]),
         .out_valid (dv_valid[j+1]),
         .out_s     (dv_s[j+1]),
         .out_r     (dv_r[j+1]),
         .out_q     (dv_q[j+1]),
         .out_flags (dv_flags[j+1])
      );
   end

   // Clamp to one, apply the sign of the negated cross product, and zero a degenerate item.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qc[k] = (dv_q[F+1][k] > {1'b1, {F{1'b0}}}) ? {1'b1, {F{1'b0}}} : dv_q[F+1][k];
         qs[k] = dv_flags[F+1].neg[k] ? -$signed({1'b0, qc[k]}) : $signed({1'b0, qc[k]});
         comp[k] = dv_flags[F+1].degen ? '0 : FIELD_WIDTH'(qs[k]);
      end
      rsp_payload_in.normal_x   = comp[0];
      rsp_payload_in.normal_y   = comp[1];
      rsp_payload_in.normal_z   = comp[2];
      rsp_payload_in.degenerate = dv_flags[F+1].degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[F+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en && dv_valid[F+1]) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `TFN_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid_ff && rsp_payload_ff.degenerate, rsp_payload_ff.normal_x == '0 && rsp_payload_ff.normal_y == '0 && rsp_payload_ff.normal_z == '0)
   `TFN_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, rsp_valid_ff && !rsp_ready)

endmodule

### sim/tb_triangle_face_normal.sv
// Testbench for triangle_face_normal: directed triangles, then random ones, checked against
// an internal predictor of the unit face normal. Depends on tfn_pkg and the RTL top level.
module tb_triangle_face_normal;
   import tfn_pkg::*;

   localparam int FRAC_BITS    = 14;
   localparam int RANDOM_ITEMS = 1540;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      tfn_req_type tri_in;
      bit          known;
      tfn_rsp_type normal;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tfn_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   tfn_rsp_type rsp_payload;

   tfn_rsp_type normal_queue[$];
   int          fail_count;
   int          idle_cycles;
   int          rsp_count;
   bit          sending_done;

   triangle_face_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic tfn_rsp_type face_normal(tfn_req_type t);
      longint      ax, ay, az, bx, by, bz;
      longint      c[3];
      logic [63:0] m[3];
      logic [127:0] sum, sq;
      logic [63:0] root, trial, quot;
      logic [127:0] rem;
      logic [15:0] comp[3];
      tfn_rsp_type r;
      ax = longint'(t.first_x) - longint'(t.second_x);
      ay = longint'(t.first_y) - longint'(t.second_y);
      az = longint'(t.first_z) - longint'(t.second_z);
      bx = longint'(t.third_x) - longint'(t.second_x);
      by = longint'(t.third_y) - longint'(t.second_y);
      bz = longint'(t.third_z) - longint'(t.second_z);
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
         sum = sum + 128'(m[i]) * 128'(m[i]);
      end
      r = '0;
      if (sum == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         sq = 128'(trial) * 128'(trial);
         if (sq <= sum) root = trial;
      end
      for (int i = 0; i < 3; i++) begin
         rem  = 128'(m[i]) << FRAC_BITS;
         quot = 64'(rem / 128'(root));
         if (quot > (64'd1 << FRAC_BITS)) quot = 64'd1 << FRAC_BITS;
         // The normal points against the cross product.
         comp[i] = (c[i] > 0) ? 16'(-quot) : 16'(quot);
      end
      r.normal_x = comp[0];
      r.normal_y = comp[1];
      r.normal_z = comp[2];
      return r;
   endfunction

   function automatic tfn_req_type make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                            int x2, int y2, int z2);
      tfn_req_type t;
      t.first_x  = 16'(x0); t.first_y  = 16'(y0); t.first_z  = 16'(z0);
      t.second_x = 16'(x1); t.second_y = 16'(y1); t.second_z = 16'(z1);
      t.third_x  = 16'(x2); t.third_y  = 16'(y2); t.third_z  = 16'(z2);
      return t;
   endfunction

   function automatic tfn_rsp_type mk_normal(int nx, int ny, int nz, bit degen);
      tfn_rsp_type r;
      r.normal_x = 16'(nx); r.normal_y = 16'(ny); r.normal_z = 16'(nz);
      r.degenerate = degen;
      return r;
   endfunction

   function automatic row_type mk_row(tfn_req_type t, bit known, tfn_rsp_type n);
      row_type row;
      row.tri_in = t;
      row.known  = known;
      row.normal = n;
      return row;
   endfunction

   function automatic int rand_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic tfn_req_type random_tri();
      tfn_req_type t;
      int          sel, span, k;
      sel = $urandom_range(99);
      if (sel < 60) begin
         t = tfn_req_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end else if (sel < 80) begin
         span = $urandom_range(1, 64);
         t = make_tri(rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span));
      end else if (sel < 92) begin
         // Collinear vertices: the third lies on the line through the other two.
         k = rand_coord(3);
         t = make_tri(rand_coord(4000), rand_coord(4000), rand_coord(4000),
                      rand_coord(4000), rand_coord(4000), rand_coord(4000), 0, 0, 0);
         t.third_x = 16'(t.second_x + k * (t.first_x - t.second_x));
         t.third_y = 16'(t.second_y + k * (t.first_y - t.second_y));
         t.third_z = 16'(t.second_z + k * (t.first_z - t.second_z));
      end else begin
         t = tfn_req_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
         if ($urandom_range(1)) begin
            t.third_x = t.second_x; t.third_y = t.second_y; t.third_z = t.second_z;
         end else begin
            t.first_x = t.third_x; t.first_y = t.third_y; t.first_z = t.third_z;
         end
      end
      return t;
   endfunction

   task automatic send_tri(tfn_req_type t, bit may_idle);
      while (may_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      row_type rows[$];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      sending_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      rows.insert(rows.size(), mk_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                      mk_normal(0, 0, 0, 1)));
      rows.insert(rows.size(), mk_row(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0), 1,
                                      mk_normal(0, 0, -16384, 0)));
      rows.insert(rows.size(), mk_row(make_tri(0, 1, 0, 0, 0, 0, 1, 0, 0), 1,
                                      mk_normal(0, 0, 16384, 0)));
      rows.insert(rows.size(), mk_row(make_tri(0, 1, 0, 0, 0, 0, 0, 0, 1), 1,
                                      mk_normal(-16384, 0, 0, 0)));
      rows.insert(rows.size(), mk_row(make_tri(0, 0, 1, 0, 0, 0, 1, 0, 0), 1,
                                      mk_normal(0, -16384, 0, 0)));
      rows.insert(rows.size(), mk_row(make_tri(5, 5, 5, 5, 5, 5, 9, -3, 7), 1,
                                      mk_normal(0, 0, 0, 1)));
      rows.insert(rows.size(), mk_row(make_tri(2, 4, 6, 1, 2, 3, 3, 6, 9), 1,
                                      mk_normal(0, 0, 0, 1)));
      rows.insert(rows.size(), mk_row(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                                               32767, -32768, 32767), 0, '0));
      rows.insert(rows.size(), mk_row(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                               -32768, -32768, 32767), 0, '0));
      rows.insert(rows.size(), mk_row(make_tri(32767, -32768, 0, -32768, 0, 32767,
                                               0, 32767, -32768), 0, '0));
      rows.insert(rows.size(), mk_row(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                               32767, 32767, 32767), 1,
                                      mk_normal(0, 0, 0, 1)));
      rows.insert(rows.size(), mk_row(make_tri(1, 1, 0, 0, 0, 0, -1, 1, 0), 0, '0));
      rows.insert(rows.size(), mk_row(make_tri(3, 0, 0, 0, 0, 0, 0, 4, 5), 0, '0));
      rows.insert(rows.size(), mk_row(make_tri(-1, -1, -1, 0, 0, 0, 1, -1, 1), 0, '0));

      foreach (rows[i]) begin
         if (rows[i].known && rows[i].normal != face_normal(rows[i].tri_in)) begin
            $error("directed row %0d: typed normal disagrees with predictor", i);
            fail_count++;
         end
         send_tri(rows[i].tri_in, 1'b1);
      end
      // A stretch in the middle of the random part runs without sender idling.
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_tri(random_tri(), !(n >= 500 && n < 800));
      req_valid    <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_count >= 200 && rsp_count < 210) begin
            // Long hold-off so the pipeline fills and backs up into the input.
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
            rsp_count = 210;
         end else if (rsp_count >= 600 && rsp_count < 900) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   always @(posedge clock) begin
      tfn_rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready)
            normal_queue.insert(normal_queue.size(), face_normal(req_payload));
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (normal_queue.size() == 0) begin
               $error("normal item with no triangle outstanding");
               fail_count++;
            end else begin
               want = normal_queue.pop_front();
               if (rsp_payload.normal_x !== want.normal_x) begin
                  $error("normal_x expected %0d actual %0d", want.normal_x, rsp_payload.normal_x);
                  fail_count++;
               end
               if (rsp_payload.normal_y !== want.normal_y) begin
                  $error("normal_y expected %0d actual %0d", want.normal_y, rsp_payload.normal_y);
                  fail_count++;
               end
               if (rsp_payload.normal_z !== want.normal_z) begin
                  $error("normal_z expected %0d actual %0d", want.normal_z, rsp_payload.normal_z);
                  fail_count++;
               end
               if (rsp_payload.degenerate !== want.degenerate) begin
                  $error("degenerate expected %0b actual %0b",
                         want.degenerate, rsp_payload.degenerate);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      while (!(sending_done && normal_queue.size() == 0)) @(posedge clock);
      repeat (70) @(posedge clock);
      if (fail_count == 0 && normal_queue.size() == 0)
         $display("triangle_face_normal verification clean");
      else
         $display("triangle_face_normal verification failed");
      $finish;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("triangle_face_normal verification failed");
      $finish;
   end

endmodule
